// ===== sv/bsa_pkg.sv =====
`timescale 1ns / 1ps

package bsa_pkg;

  // Slot space
  localparam int SLOTS      = 256;
  localparam int SLOT_LIMIT = (SLOTS > 256) ? 256 : SLOTS;
  localparam int SLOT_W     = 8;
  localparam int GEN_W      = 8;
  localparam int STATUS_W   = 2;

  // Free map layout: four 64-bit words
  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = 6;
  localparam int NUM_WORDS  = 4;
  localparam int WSEL_W     = 2;
  localparam int MAP_BITS   = NUM_WORDS * WORD_BITS;

  // Request kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_FULL         = 2'd1,
    STATUS_ALREADY_FREE = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Slots that allocate may hand out
  function automatic logic [MAP_BITS-1:0] slot_mask();
    logic [MAP_BITS-1:0] m;
    for (int i = 0; i < MAP_BITS; i++) begin
      m[i] = (i < SLOT_LIMIT);
    end
    return m;
  endfunction

  localparam logic [MAP_BITS-1:0] SLOT_MASK = slot_mask();

endpackage

// ===== sv/bsa_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port.
module bsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bitmap_slot_allocator_with_generations_top.sv =====
`timescale 1ns / 1ps
// The input transfer loads the request registers and issues the RAM read;
//   out_valid is set when the update cycle ends, once the output is free.
// A new request is taken only in the idle state, one in flight at a time, set by
//   the read-modify-write of the generation RAM (write-back as the update ends).
// A stalled output holds the block in its update cycle until the result is taken.
// Reset (rst, synchronous): free map all ones, generation valid bits cleared, so
//   every generation reads as zero; no clearing pass, requests taken right away.

module bitmap_slot_allocator_with_generations_top (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [bsa_pkg::SLOT_W-1:0]    slot_index,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bsa_pkg::STATUS_W-1:0]  status,
  output logic [bsa_pkg::SLOT_W-1:0]    granted_slot,
  output logic [bsa_pkg::GEN_W-1:0]     generation
);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  bsa_pkg::state_t state, state_next;

  // Free map, 1 = free. Kept in flops so the lowest free slot is found in
  // the transfer cycle: per-word OR, 4-way priority, then a 64-bit encode.
  logic [bsa_pkg::NUM_WORDS-1:0][bsa_pkg::WORD_BITS-1:0] free_map;

  // One valid bit per generation entry; an entry never written reads as zero.
  // Sized for the full index range so a release beyond the slot range reads zero.
  logic [bsa_pkg::MAP_BITS-1:0] gen_valid;

  // Request captured at the input transfer
  logic                        kind_q;
  logic [bsa_pkg::SLOT_W-1:0]  slot_q;
  logic                        full_q;

  // Output register
  logic [bsa_pkg::STATUS_W-1:0] status_q;
  logic [bsa_pkg::SLOT_W-1:0]   granted_q;
  logic [bsa_pkg::GEN_W-1:0]    gen_q;

  // ---------------------------------------------------------------------------
  // Lowest free slot search (transfer cycle)
  // ---------------------------------------------------------------------------
  logic [bsa_pkg::NUM_WORDS-1:0][bsa_pkg::WORD_BITS-1:0] avail;
  logic [bsa_pkg::NUM_WORDS-1:0] word_avail;
  logic [bsa_pkg::WSEL_W-1:0]    wsel;
  logic [bsa_pkg::WORD_BITS-1:0] sel_word;
  logic [bsa_pkg::WORD_SHIFT-1:0] bit_idx;
  logic                          any_free;
  logic [bsa_pkg::SLOT_W-1:0]    alloc_slot;

  always_comb begin
    avail      = free_map & bsa_pkg::SLOT_MASK;
    for (int w = 0; w < bsa_pkg::NUM_WORDS; w++) begin
      word_avail[w] = |avail[w];
    end
    any_free = |word_avail;

    wsel = '0;
    for (int w = bsa_pkg::NUM_WORDS - 1; w >= 0; w--) begin
      if (word_avail[w]) begin
        wsel = bsa_pkg::WSEL_W'(w);
      end
    end
    sel_word = avail[wsel];

    bit_idx = '0;
    for (int i = bsa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (sel_word[i]) begin
        bit_idx = bsa_pkg::WORD_SHIFT'(i);
      end
    end
    alloc_slot = {wsel, bit_idx};
  end

  // ---------------------------------------------------------------------------
  // Generation RAM
  // ---------------------------------------------------------------------------
  logic                        ram_we;
  logic                        ram_re;
  logic [bsa_pkg::SLOT_W-1:0]  ram_raddr;
  logic [bsa_pkg::GEN_W-1:0]   ram_wdata;
  logic [bsa_pkg::GEN_W-1:0]   ram_rdata;

  bsa_ram #(
    .WIDTH (bsa_pkg::GEN_W),
    .DEPTH (bsa_pkg::MAP_BITS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_q),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Update cycle: read data back, decide, write back and load the result
  // ---------------------------------------------------------------------------
  logic                         in_xfer;
  logic                         out_free;
  logic                         done;
  logic [bsa_pkg::GEN_W-1:0]    cur_gen;
  logic [bsa_pkg::GEN_W-1:0]    gen_inc;
  logic                         slot_free;
  logic                         clear_bit;
  logic                         set_bit;
  logic [bsa_pkg::STATUS_W-1:0] res_status;
  logic [bsa_pkg::SLOT_W-1:0]   res_slot;
  logic [bsa_pkg::GEN_W-1:0]    res_gen;

  always_comb begin
    in_ready   = (state == bsa_pkg::ST_IDLE);
    in_xfer    = in_valid && in_ready;
    out_free   = !out_valid || out_ready;

    ram_re     = in_xfer;
    ram_raddr  = (kind == bsa_pkg::KIND_RELEASE) ? slot_index : alloc_slot;

    cur_gen    = gen_valid[slot_q] ? ram_rdata : '0;
    gen_inc    = cur_gen + 1'b1;
    slot_free  = free_map[slot_q[bsa_pkg::SLOT_W-1:bsa_pkg::WORD_SHIFT]]
                         [slot_q[bsa_pkg::WORD_SHIFT-1:0]];

    clear_bit  = 1'b0;
    set_bit    = 1'b0;
    res_status = bsa_pkg::STATUS_OK;
    res_slot   = slot_q;
    res_gen    = gen_inc;
    if (kind_q == bsa_pkg::KIND_ALLOC) begin
      if (full_q) begin
        res_status = bsa_pkg::STATUS_FULL;
        res_slot   = '0;
        res_gen    = '0;
      end else begin
        clear_bit  = 1'b1;
      end
    end else begin
      if (slot_free) begin
        // release of a free slot: echo, nothing changes
        res_status = bsa_pkg::STATUS_ALREADY_FREE;
        res_gen    = cur_gen;
      end else begin
        set_bit    = 1'b1;
      end
    end

    done       = (state == bsa_pkg::ST_UPDATE) && out_free;
    ram_we     = done && (clear_bit || set_bit);
    ram_wdata  = gen_inc;

    state_next = state;
    case (state)
      bsa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = bsa_pkg::ST_UPDATE;
        end
      end
      bsa_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_next = bsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map  <= '1;
      gen_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ram_we) begin
        free_map[slot_q[bsa_pkg::SLOT_W-1:bsa_pkg::WORD_SHIFT]]
                [slot_q[bsa_pkg::WORD_SHIFT-1:0]] <= set_bit;
        gen_valid[slot_q] <= 1'b1;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_q <= kind;
      slot_q <= ram_raddr;
      full_q <= !any_free;
    end
    if (done) begin
      status_q  <= res_status;
      granted_q <= res_slot;
      gen_q     <= res_gen;
    end
  end

  assign status       = status_q;
  assign granted_slot = granted_q;
  assign generation   = gen_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // a granted allocation always takes a slot that was free and allocatable
  assert property (@(posedge clk) disable iff (rst)
    (done && kind_q == bsa_pkg::KIND_ALLOC && !full_q) |->
      (slot_free && bsa_pkg::SLOT_MASK[slot_q]))
    else $error("allocation granted a slot that was not free");

  // a full report only when no allocatable slot is free
  assert property (@(posedge clk) disable iff (rst)
    (done && kind_q == bsa_pkg::KIND_ALLOC && full_q) |-> !any_free)
    else $error("full reported while a slot is free");

  // a generation write-back leaves that entry marked valid
  assert property (@(posedge clk) disable iff (rst)
    ram_we |=> gen_valid[$past(slot_q)])
    else $error("generation entry not marked valid after write");

  // a new result only comes out of the update cycle
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> $past(state == bsa_pkg::ST_UPDATE))
    else $error("result appeared without an update cycle");

  // the free map moves by at most one slot per cycle
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |->
      ($countones(free_map) == $past($countones(free_map)) ||
       $countones(free_map) == $past($countones(free_map)) + 1 ||
       $countones(free_map) + 1 == $past($countones(free_map))))
    else $error("free map changed by more than one slot");

endmodule

// ===== tb/bitmap_slot_allocator_with_generations_top_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the slot allocator.
// A scoreboard object keeps its own free map and generation table, predicts
// one grant per accepted request and compares every result transfer with the
// oldest prediction. Plain tasks drive the request channel. The result
// channel is stalled at random by an always block.
module bitmap_slot_allocator_with_generations_top_tb;

  localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int MAX_REPORTS = 40;    // keeps the log short if the block is badly off
  localparam int DRAIN_TAIL  = 8;     // extra idle time after the final drain

  // One predicted result.
  typedef struct {
    bsa_pkg::status_t               status;
    logic [bsa_pkg::SLOT_W-1:0]     slot;
    logic [bsa_pkg::GEN_W-1:0]      gen;
  } grant_t;

  // Shadow allocator plus the queue of grants still owed by the block.
  class slot_scoreboard;
    bit [bsa_pkg::WORD_BITS-1:0] free_words [bsa_pkg::NUM_WORDS];
    bit [bsa_pkg::GEN_W-1:0]     gen_table [bsa_pkg::MAP_BITS];
    grant_t                      owed_q [$];
    int errors, checked, allocs, fulls, releases, double_frees, wraps;

    function new();
      foreach (free_words[w]) free_words[w] = '1;
      foreach (gen_table[s]) gen_table[s] = '0;
    endfunction

    function bit is_free(int s);
      return free_words[s >> bsa_pkg::WORD_SHIFT][s % bsa_pkg::WORD_BITS];
    endfunction

    function void set_free(int s, bit value);
      free_words[s >> bsa_pkg::WORD_SHIFT][s % bsa_pkg::WORD_BITS] = value;
    endfunction

    // Generation counter moves on every grant and every real release.
    function void bump(int s);
      gen_table[s] = gen_table[s] + 1'b1;
      if (gen_table[s] == '0) wraps++;
    endfunction

    // Called at the request transfer; returns the grant it predicts.
    function grant_t note_request(logic k, logic [bsa_pkg::SLOT_W-1:0] idx);
      grant_t g;
      g = '{status: bsa_pkg::STATUS_FULL, slot: '0, gen: '0};
      if (k == bsa_pkg::KIND_ALLOC) begin
        allocs++;
        for (int s = 0; s < bsa_pkg::SLOT_LIMIT; s++) begin
          if (is_free(s)) begin
            set_free(s, 1'b0);
            bump(s);
            g = '{status: bsa_pkg::STATUS_OK, slot: bsa_pkg::SLOT_W'(s),
                  gen: gen_table[s]};
            break;
          end
        end
        if (g.status == bsa_pkg::STATUS_FULL) fulls++;
      end else begin
        releases++;
        if (is_free(idx)) begin
          // already free, or beyond the slot range: nothing changes
          double_frees++;
          g = '{status: bsa_pkg::STATUS_ALREADY_FREE, slot: idx, gen: gen_table[idx]};
        end else begin
          set_free(idx, 1'b1);
          bump(idx);
          g = '{status: bsa_pkg::STATUS_OK, slot: idx, gen: gen_table[idx]};
        end
      end
      owed_q.push_back(g);
      return g;
    endfunction

    // Random slot currently held; a random index if none is held.
    function logic [bsa_pkg::SLOT_W-1:0] pick_used();
      int used_q [$];
      for (int s = 0; s < bsa_pkg::SLOT_LIMIT; s++) begin
        if (!is_free(s)) used_q.push_back(s);
      end
      if (used_q.size() == 0)
        return bsa_pkg::SLOT_W'($urandom_range(bsa_pkg::MAP_BITS - 1));
      return bsa_pkg::SLOT_W'(used_q[$urandom_range(used_q.size() - 1)]);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void mismatch(string what, int want, int got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic [bsa_pkg::STATUS_W-1:0] st,
                               logic [bsa_pkg::SLOT_W-1:0] sl,
                               logic [bsa_pkg::GEN_W-1:0] gn);
      grant_t e;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual status=%0d slot=%0d gen=%0d",
                   $time, st, sl, gn);
        return;
      end
      e = owed_q.pop_front();
      checked++;
      if (st !== e.status) mismatch("status", e.status, st);
      if (sl !== e.slot)   mismatch("granted_slot", e.slot, sl);
      if (gn !== e.gen)    mismatch("generation", e.gen, gn);
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic                          kind;
  logic [bsa_pkg::SLOT_W-1:0]    slot_index;
  logic                          out_valid;
  logic                          out_ready;
  logic [bsa_pkg::STATUS_W-1:0]  status;
  logic [bsa_pkg::SLOT_W-1:0]    granted_slot;
  logic [bsa_pkg::GEN_W-1:0]     generation;

  slot_scoreboard sb = new();

  int send_idle_pct;   // chance per cycle that the sender holds off
  int recv_stall_pct;  // chance per cycle that out_ready is low
  int stall_cycles;

  bitmap_slot_allocator_with_generations_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .slot_index   (slot_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .granted_slot (granted_slot),
    .generation   (generation)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random back-pressure, and every result transfer is checked.
  // Sampling at the edge sees pre-edge values, so no race with the block.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready)
      sb.check_result(status, granted_slot, generation);
  end

  // Watchdog: too long with no transfer on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still owed",
                 $time, STALL_LIMIT, sb.pending());
        $display("** bitmap_slot_allocator_with_generations_top: FAILED **");
        $finish;
      end
    end
  end

  // One request transfer. Valid is lowered only when the sender idles, so a
  // back-to-back request never sees two assignments to in_valid in one step.
  task automatic send_request(input logic k, input logic [bsa_pkg::SLOT_W-1:0] idx,
                              output grant_t g);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    slot_index <= idx;
    do @(posedge clk); while (!in_ready);
    g = sb.note_request(k, idx);
  endtask

  task automatic send_random();
    grant_t g;
    send_request(1'($urandom_range(1)),
                 bsa_pkg::SLOT_W'($urandom_range(bsa_pkg::MAP_BITS - 1)), g);
  endtask

  // Sender pauses until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mostly allocates, so the map fills and the full case is hit repeatedly.
  task automatic run_grow(input int n);
    grant_t g;
    repeat (n) begin
      if ($urandom_range(99) < 95)
        send_request(bsa_pkg::KIND_ALLOC,
                     bsa_pkg::SLOT_W'($urandom_range(bsa_pkg::MAP_BITS - 1)), g);
      else
        send_request(bsa_pkg::KIND_RELEASE,
                     bsa_pkg::SLOT_W'($urandom_range(bsa_pkg::MAP_BITS - 1)), g);
    end
  endtask

  // Release then re-allocate the same slot. Allocation always takes the
  // lowest free slot, so this hammers slot 0 and walks its generation
  // through the 255 -> 0 wrap over the run.
  task automatic run_churn(input int pairs);
    grant_t g;
    logic [bsa_pkg::SLOT_W-1:0] hot;
    hot = '0;
    repeat (pairs) begin
      if ($urandom_range(99) < 10) begin
        send_random();
      end else begin
        send_request(bsa_pkg::KIND_RELEASE, hot, g);
        send_request(bsa_pkg::KIND_ALLOC,
                     bsa_pkg::SLOT_W'($urandom_range(bsa_pkg::MAP_BITS - 1)), g);
        if (g.status == bsa_pkg::STATUS_OK) hot = g.slot;
      end
    end
  endtask

  // Mostly frees held slots, with some stray releases and allocates mixed in.
  task automatic run_shrink(input int n);
    grant_t g;
    repeat (n) begin
      if ($urandom_range(99) < 90)
        send_request(bsa_pkg::KIND_RELEASE, sb.pick_used(), g);
      else
        send_random();
    end
  endtask

  initial begin
    grant_t g;
    rst            = 1'b1;
    in_valid       = 1'b0;
    kind           = bsa_pkg::KIND_ALLOC;
    slot_index     = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: releases of free slots at both index extremes, first
    // allocations, release and re-grant of the lowest slot, double release.
    send_request(bsa_pkg::KIND_RELEASE, 8'd0,   g);
    send_request(bsa_pkg::KIND_RELEASE, 8'd255, g);
    send_request(bsa_pkg::KIND_ALLOC,   8'hFF,  g);
    send_request(bsa_pkg::KIND_ALLOC,   8'h00,  g);
    send_request(bsa_pkg::KIND_ALLOC,   8'hAA,  g);
    send_request(bsa_pkg::KIND_ALLOC,   8'h55,  g);
    send_request(bsa_pkg::KIND_RELEASE, 8'd1,   g);
    send_request(bsa_pkg::KIND_RELEASE, 8'd1,   g);   // second release of the same slot
    send_request(bsa_pkg::KIND_ALLOC,   8'd200, g);   // must get slot 1 back
    send_request(bsa_pkg::KIND_RELEASE, 8'd0,   g);
    send_request(bsa_pkg::KIND_RELEASE, 8'd2,   g);
    send_request(bsa_pkg::KIND_ALLOC,   8'd0,   g);   // lowest free: slot 0
    send_request(bsa_pkg::KIND_ALLOC,   8'd0,   g);   // then slot 2
    send_request(bsa_pkg::KIND_ALLOC,   8'd0,   g);   // then slot 4
    send_request(bsa_pkg::KIND_RELEASE, 8'd3,   g);
    send_request(bsa_pkg::KIND_RELEASE, 8'd128, g);   // never allocated
    send_request(bsa_pkg::KIND_RELEASE, 8'd127, g);
    send_request(bsa_pkg::KIND_RELEASE, 8'd4,   g);
    send_request(bsa_pkg::KIND_RELEASE, 8'd3,   g);   // already freed above
    send_request(bsa_pkg::KIND_ALLOC,   8'hFF,  g);
    drain();

    // Three idling profiles: sender light / receiver heavy, swapped, none.
    // The full-map case comes from the grow stretches once the map has filled up.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 8  : (ph == 1) ? 66 : 0;
      recv_stall_pct = (ph == 0) ? 66 : (ph == 1) ? 8  : 0;
      run_grow(200);
      run_churn(80);
      run_shrink(70);
      drain();
    end

    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Run covered %0d requests: %0d allocates (%0d on a full map), %0d releases",
             sb.allocs + sb.releases, sb.allocs, sb.fulls, sb.releases);
    $display("(%0d of an already free slot), %0d generation wraps, %0d results checked",
             sb.double_frees, sb.wraps, sb.checked);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** bitmap_slot_allocator_with_generations_top: PASSED **");
    else
      $display("** bitmap_slot_allocator_with_generations_top: FAILED **");
    $finish;
  end

endmodule
